// File: rtl/kvt_pkg.sv
package kvt_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_W = 32;
    localparam int VALUE_W = 32;

    typedef enum logic [2:0] {
        OP_INSERT  = 3'd0,
        OP_FIND    = 3'd1,
        OP_REMOVE  = 3'd2,
        OP_ITERATE = 3'd3,
        OP_CLEAR   = 3'd4
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_FULL     = 3'd2,
        ST_NULL     = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_EMPTY    = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_INSERT,
        S_RESP,
        S_ITER_RD,
        S_ITER_OUT,
        S_SHIFT_RD,
        S_SHIFT_WR
    } state_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_ZERO,
        IDX_INC,
        IDX_DEC,
        IDX_TOP
    } idx_op_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_NEW,
        WR_SHIFT
    } wr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } cnt_op_t;

    typedef enum logic [1:0] {
        KEY_ZERO,
        KEY_REQ,
        KEY_RD
    } key_sel_t;

    typedef enum logic {
        VAL_ZERO,
        VAL_RD
    } val_sel_t;

    typedef struct packed {
        logic     load_in;
        idx_op_t  idx_op;
        logic     rd_en;
        logic     rd_plus1;
        wr_op_t   wr_op;
        cnt_op_t  cnt_op;
        logic     out_load;
        status_t  out_status;
        key_sel_t key_sel;
        val_sel_t val_sel;
        logic     out_last;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       val_zero;
        logic       cnt_zero;
        logic       full;
        logic       hit;
        logic       idx_last;
        logic       idx_zero;
        logic       out_free;
    } sts_t;

endpackage

// File: rtl/kvt_ctrl.sv
module kvt_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  kvt_pkg::sts_t sts,
    output kvt_pkg::cmd_t cmd
);
    import kvt_pkg::*;

    state_t  state_reg, state_next;
    status_t resp_reg, resp_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            resp_reg  <= ST_OK;
        end
        else
        begin
            state_reg <= state_next;
            resp_reg  <= resp_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        resp_next      = resp_reg;
        in_ready       = 1'b0;
        cmd.load_in    = 1'b0;
        cmd.idx_op     = IDX_HOLD;
        cmd.rd_en      = 1'b0;
        cmd.rd_plus1   = 1'b0;
        cmd.wr_op      = WR_NONE;
        cmd.cnt_op     = CNT_HOLD;
        cmd.out_load   = 1'b0;
        cmd.out_status = ST_OK;
        cmd.key_sel    = KEY_ZERO;
        cmd.val_sel    = VAL_ZERO;
        cmd.out_last   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    cmd.idx_op  = IDX_ZERO;
                    state_next  = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.op) inside
                    OP_INSERT:
                    begin
                        if (sts.val_zero)
                        begin
                            resp_next  = ST_NULL;
                            state_next = S_RESP;
                        end
                        else if (sts.cnt_zero)
                        begin
                            state_next = S_INSERT;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    OP_FIND, OP_REMOVE:
                    begin
                        if (sts.cnt_zero)
                        begin
                            resp_next  = ST_NOTFOUND;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            state_next = S_SCAN_RD;
                        end
                    end
                    OP_ITERATE:
                    begin
                        if (sts.cnt_zero)
                        begin
                            resp_next  = ST_EMPTY;
                            state_next = S_RESP;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_TOP;
                            state_next = S_ITER_RD;
                        end
                    end
                    OP_CLEAR:
                    begin
                        cmd.cnt_op = CNT_CLR;
                        resp_next  = ST_OK;
                        state_next = S_RESP;
                    end
                    default:
                    begin
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                if (sts.hit)
                begin
                    resp_next  = (sts.op == OP_INSERT) ? ST_DUP : ST_OK;
                    state_next = S_RESP;
                end
                else if (sts.idx_last)
                begin
                    if (sts.op == OP_INSERT)
                    begin
                        state_next = S_INSERT;
                    end
                    else
                    begin
                        resp_next  = ST_NOTFOUND;
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                    state_next = S_SCAN_RD;
                end
            end
            S_INSERT:
            begin
                if (sts.full)
                begin
                    resp_next = ST_FULL;
                end
                else
                begin
                    cmd.wr_op  = WR_NEW;
                    cmd.cnt_op = CNT_INC;
                    resp_next  = ST_OK;
                end
                state_next = S_RESP;
            end
            S_RESP:
            begin
                cmd.out_status = resp_reg;
                if (sts.op == OP_FIND || sts.op == OP_REMOVE)
                begin
                    cmd.key_sel = KEY_REQ;
                    if (resp_reg == ST_OK)
                    begin
                        cmd.val_sel = VAL_RD;
                    end
                end
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.op == OP_REMOVE && resp_reg == ST_OK)
                    begin
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_ITER_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_ITER_OUT;
            end
            S_ITER_OUT:
            begin
                cmd.out_status = ST_OK;
                cmd.key_sel    = KEY_RD;
                cmd.val_sel    = VAL_RD;
                cmd.out_last   = sts.idx_zero;
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (sts.idx_zero)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.idx_op = IDX_DEC;
                        state_next = S_ITER_RD;
                    end
                end
            end
            S_SHIFT_RD:
            begin
                if (sts.idx_last)
                begin
                    cmd.cnt_op = CNT_DEC;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.rd_en    = 1'b1;
                    cmd.rd_plus1 = 1'b1;
                    state_next   = S_SHIFT_WR;
                end
            end
            S_SHIFT_WR:
            begin
                cmd.wr_op  = WR_SHIFT;
                cmd.idx_op = IDX_INC;
                state_next = S_SHIFT_RD;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DISPATCH))
        else $error("accepted word not dispatched");

    a_resp_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESP && !sts.out_free) |=> (state_reg == S_RESP))
        else $error("response dropped while output stalled");
`endif

endmodule

// File: rtl/kvt_dpath.sv
module kvt_dpath #(
    parameter int CAPACITY = kvt_pkg::CAPACITY_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  kvt_pkg::cmd_t                 cmd,
    output kvt_pkg::sts_t                 sts,
    input  logic [2:0]                    op,
    input  logic [kvt_pkg::KEY_W-1:0]     key,
    input  logic [kvt_pkg::VALUE_W-1:0]   value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [2:0]                    status,
    output logic [kvt_pkg::KEY_W-1:0]     out_key,
    output logic [kvt_pkg::VALUE_W-1:0]   out_value,
    output logic                          last
);
    import kvt_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = KEY_W + VALUE_W;

    logic [EW-1:0]      entry_mem [CAPACITY];
    logic [EW-1:0]      rd_data_reg;
    logic [2:0]         op_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    logic [CW-1:0]      cnt_m1;
    logic [AW-1:0]      rd_addr, wr_addr;
    logic [EW-1:0]      wr_data;
    logic               wr_en;
    logic               out_valid_reg, out_valid_next;
    logic [2:0]         status_reg;
    logic [KEY_W-1:0]   out_key_reg, out_key_next;
    logic [VALUE_W-1:0] out_value_reg, out_value_next;
    logic               last_reg;
    logic               out_free;

    assign cnt_m1   = cnt_reg - CW'(1);
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        unique case (cmd.idx_op)
            IDX_ZERO: idx_next = '0;
            IDX_INC:  idx_next = idx_reg + AW'(1);
            IDX_DEC:  idx_next = idx_reg - AW'(1);
            IDX_TOP:  idx_next = cnt_m1[AW-1:0];
            default:  idx_next = idx_reg;
        endcase
        unique case (cmd.cnt_op)
            CNT_INC: cnt_next = cnt_reg + CW'(1);
            CNT_DEC: cnt_next = cnt_m1;
            CNT_CLR: cnt_next = '0;
            default: cnt_next = cnt_reg;
        endcase
    end

    assign rd_addr = cmd.rd_plus1 ? idx_reg + AW'(1) : idx_reg;
    assign wr_en   = (cmd.wr_op != WR_NONE);
    assign wr_addr = (cmd.wr_op == WR_NEW) ? cnt_reg[AW-1:0] : idx_reg;
    assign wr_data = (cmd.wr_op == WR_NEW) ? {key_reg, value_reg} : rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            op_reg    <= op;
            key_reg   <= key;
            value_reg <= value;
        end
        if (cmd.out_load)
        begin
            status_reg    <= cmd.out_status;
            out_key_reg   <= out_key_next;
            out_value_reg <= out_value_next;
            last_reg      <= cmd.out_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        unique case (cmd.key_sel)
            KEY_REQ: out_key_next = key_reg;
            KEY_RD:  out_key_next = rd_data_reg[EW-1:VALUE_W];
            default: out_key_next = '0;
        endcase
        out_value_next = (cmd.val_sel == VAL_RD) ? rd_data_reg[VALUE_W-1:0] : '0;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign sts.op       = op_reg;
    assign sts.val_zero = (value_reg == '0);
    assign sts.cnt_zero = (cnt_reg == '0);
    assign sts.full     = (cnt_reg == CW'(CAPACITY));
    assign sts.hit      = (rd_data_reg[EW-1:VALUE_W] == key_reg);
    assign sts.idx_last = (CW'(idx_reg) == cnt_m1);
    assign sts.idx_zero = (idx_reg == '0);
    assign sts.out_free = out_free;

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign out_key   = out_key_reg;
    assign out_value = out_value_reg;
    assign last      = last_reg;

`ifndef NO_ASSERTIONS
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("output word overwritten before taken");

    a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.wr_op == WR_NEW) |-> (cnt_reg < CW'(CAPACITY)))
        else $error("insert into full table");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.cnt_op == CNT_INC) |=> (cnt_reg == $past(cnt_reg) + CW'(1)))
        else $error("entry count did not advance");
`endif

endmodule

// File: rtl/keyed_value_table.sv
// keyed value table: up to CAPACITY unique signed keys, each with a nonzero value
// input channel in_valid/in_ready carries op, key, value; one word at a time
// output channel out_valid/out_ready carries status, out_key, out_value, last
// entries live in a memory with separate read and write addresses, oldest in slot 0, newest at the top
// lookups read then compare one entry at a time, oldest first; find and remove
//   load their result word when the scan hits or ends, insert after its insert step
// remove then closes the gap by moving each entry above the removed slot down
//   one slot, then drops the count
// iterate emits newest first, one word per entry read, with last set on the
//   final word
// clear, a zero-value insert, and find, remove or iterate on an empty table
//   load their result word straight after dispatch, without scanning the table
// in_ready is high only in idle, which is reentered once the last result word
//   loads or, after a remove, once the gap is closed; a result waiting in the
//   output register does not keep the next word from being accepted
// when the receiver stalls, the output register holds its word and the
//   controller waits before loading the next one
// unused op codes produce no result, leave the table untouched and return to idle from dispatch
// reset empties the table at once; no clearing pass is needed
module keyed_value_table #(
    parameter int CAPACITY = kvt_pkg::CAPACITY_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [2:0]                           op,
    input  logic signed [kvt_pkg::KEY_W-1:0]     key,
    input  logic [kvt_pkg::VALUE_W-1:0]          value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [2:0]                           status,
    output logic signed [kvt_pkg::KEY_W-1:0]     out_key,
    output logic [kvt_pkg::VALUE_W-1:0]          out_value,
    output logic                                 last
);
    import kvt_pkg::*;

    cmd_t cmd;
    sts_t sts;

    kvt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    kvt_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .op        (op),
        .key       (key),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .out_key   (out_key),
        .out_value (out_value),
        .last      (last)
    );

endmodule
